// ----- rtl/mdm_pkg.sv -----
// Package for the magnitude to density mapper.
// Holds codes, controller states, micro-ops and the command/status structs.
// No dependencies.
package mdm_pkg;

    localparam int DENS_W = 24;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MAP   = 2'd2;

    localparam logic [1:0] MODE_LIN  = 2'd0;
    localparam logic [1:0] MODE_POLY = 2'd1;
    localparam logic [1:0] MODE_SIG  = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_PEAK  = 2'd1;
    localparam logic [1:0] REG_FLOOR = 2'd2;

    localparam logic [1:0]        MODE_RESET  = MODE_POLY;
    localparam logic [DENS_W-1:0] PEAK_RESET  = 24'd12288000;
    localparam logic [DENS_W-1:0] FLOOR_RESET = 24'd410;

    typedef enum logic [4:0] {
        MOP_NONE,
        MOP_LATCH,
        MOP_CLEAR,
        MOP_ACCUM,
        MOP_PREP,
        MOP_DIV_LIN,
        MOP_DIV_MID,
        MOP_DIV_UP,
        MOP_MUL_UU,
        MOP_MUL_U3,
        MOP_MUL_F,
        MOP_MUL_POS,
        MOP_MUL_INTERP,
        MOP_MUL_BLEND_POLY,
        MOP_MUL_BLEND_SIG,
        MOP_MUL_W2,
        MOP_MUL_DROP,
        MOP_RES_LIN,
        MOP_RES_BLEND,
        MOP_RES_DROP,
        MOP_RES_FLOOR,
        MOP_RES_PEAK,
        MOP_RES_ZERO,
        MOP_RES_DEGEN,
        MOP_OUT
    } mop_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BRANCH,
        ST_DIV_LIN,
        ST_LIN_RES,
        ST_DIV_MID,
        ST_POLY_U2,
        ST_POLY_U3,
        ST_POLY_F,
        ST_POLY_BLEND,
        ST_SIG_POS,
        ST_SIG_INTERP,
        ST_SIG_BLEND,
        ST_BLEND_RES,
        ST_DIV_UP,
        ST_UP_W2,
        ST_UP_DROP,
        ST_UP_RES,
        ST_OUT
    } state_t;

    typedef struct packed {
        mop_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [1:0]       mode;
        logic             degen;
        logic             low;
        logic             mid;
        logic             up_zero;
        logic             div_busy;
        logic             out_free;
    } dp_stat_t;

endpackage

// ----- rtl/magnitude_to_density_mapper_unit.sv -----
// Top level of the magnitude to density mapper.
// Depends on mdm_pkg, mdm_controller, mdm_datapath (with mdm_divider).
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser: command; s_tdata: sample
//  m_      | out | m_tvalid/m_tready  | m_tdata: density; m_tuser: degenerate
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_addr: register; cfg_data: value
//
// Clear and accumulate requests are handled on decode; a degenerate map and a map settled
// by a border compare go straight to the output state. Maps that divide run the divider
// and then their control and multiply steps.
// Synchronous active-low reset; no clearing pass, the logistic table is constant.
// A result waits in the output register while the next request is accepted;
// a map stalls in its last cycle while that register is still full.
module magnitude_to_density_mapper_unit
    import mdm_pkg::*;
#(
    parameter int SAMPLE_WIDTH         = 32,
    parameter int LOGISTIC_TABLE_DEPTH = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,   // sample
    input  logic [CMD_W-1:0]                     s_tuser,   // command
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [DENS_W-1:0]                    m_tdata,   // density
    output logic [0:0]                           m_tuser,   // degenerate
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_addr,
    input  logic [DENS_W-1:0]                    cfg_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     degen;

    assign cfg_ready  = aresetn;
    assign m_tuser[0] = degen;

    mdm_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mdm_datapath #(
        .SAMPLE_WIDTH         (SAMPLE_WIDTH),
        .LOGISTIC_TABLE_DEPTH (LOGISTIC_TABLE_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample_in    (s_tdata[SAMPLE_WIDTH-1:0]),
        .cmd_in       (s_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_density    (m_tdata),
        .m_degenerate (degen),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ----- rtl/mdm_divider.sv -----
// Restoring long divider, one quotient bit per cycle.
// Uses no package.
module mdm_divider #(
    parameter int NUM_W = 55,
    parameter int DEN_W = 39
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next, den_reg;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
        rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next  = {quo_reg[NUM_W-2:0], ge};
        cnt_next  = cnt_reg - CNT_W'(1);
        busy_next = cnt_reg != CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ----- rtl/mdm_datapath.sv -----
// Datapath: config and statistics registers, shared multiplier, logistic table,
// divider instance and output register. Depends on mdm_pkg and mdm_divider.
module mdm_datapath
    import mdm_pkg::*;
#(
    parameter int SAMPLE_WIDTH         = 32,
    parameter int LOGISTIC_TABLE_DEPTH = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [CMD_W-1:0]        cmd_in,
    input  logic                    cfg_valid,
    input  logic [1:0]              cfg_addr,
    input  logic [DENS_W-1:0]       cfg_data,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DENS_W-1:0]       m_density,
    output logic                    m_degenerate,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat
);
    localparam int W     = SAMPLE_WIDTH;
    localparam int DW    = W + 7;
    localparam int NW    = DW + 16;
    localparam int IDX_W = $clog2(LOGISTIC_TABLE_DEPTH);
    localparam int IW    = $clog2(LOGISTIC_TABLE_DEPTH + 1);
    localparam int PW    = 45;

    typedef logic [16:0] rom_t [0:LOGISTIC_TABLE_DEPTH];

    // shift-subtract quotient, only evaluated while building the table
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_q24(input logic [63:0] y);
        logic [63:0] sum;
        logic [63:0] term;
        int          k;
        sum  = 64'd16777216;
        term = 64'd16777216;
        k    = 1;
        while (k < 64 && term != 64'd0) begin
            term = udiv((term * y) >> 24, 64'(k));
            sum  = sum + term;
            k    = k + 1;
        end
        return sum;
    endfunction

    function automatic logic [63:0] sig_at(input int i);
        logic [63:0] step;
        logic [63:0] four;
        logic [63:0] z;
        step = udiv(64'd134217728 * 64'(i), 64'(LOGISTIC_TABLE_DEPTH));
        four = 64'd67108864;
        if (step <= four) z = exp_q24(four - step);
        else z = udiv(64'd1 << 48, exp_q24(step - four));
        return udiv(64'd1 << 48, 64'd16777216 + z);
    endfunction

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] s;
        logic [63:0] e;
        lo = sig_at(0);
        hi = sig_at(LOGISTIC_TABLE_DEPTH);
        for (int i = 0; i <= LOGISTIC_TABLE_DEPTH; i++) begin
            s = sig_at(i);
            e = (s <= lo) ? 64'd0 : udiv((s - lo) * 64'd65536, hi - lo);
            r[i] = (e > 64'd65536) ? 17'd65536 : e[16:0];
        end
        return r;
    endfunction

    localparam rom_t LOGI_ROM = build_rom();

    logic [1:0]        mode_reg;
    logic [DENS_W-1:0] peak_reg, floor_reg;
    logic [W-1:0]      min_reg, max_reg;
    logic              any_seen_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [W-1:0]      mag_reg, d_reg, span_reg;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [16:0]       a_reg;
    logic              dir_reg;
    logic [DENS_W-1:0] res_reg, res_next;
    logic              res_degen_reg;
    logic [DENS_W-1:0] out_data_reg;
    logic              out_degen_reg, out_valid_reg;

    logic [W-1:0]      mag_in, d_next, span_next;
    logic [DW-1:0]     s1, s2, s89, s9, d100, d10, num_up;
    logic              div_start, div_busy;
    logic [NW-1:0]     div_num, div_quo;
    logic [DW-1:0]     div_den;
    logic [16:0]       u_val, l_val, f_clamp, blend_f;
    logic [18:0]       g_val;
    logic [28:0]       f_raw;
    logic [IDX_W-1:0]  idx;
    logic [IW-1:0]     idx0, idx1;
    logic [16:0]       ta, tb;
    logic [DENS_W-1:0] diff_pf;
    logic              up_dir;
    logic [26:0]       drop;
    logic [25:0]       mul_a;
    logic [18:0]       mul_b;

    assign mag_in    = sample_in[W-1] ? (~sample_in + W'(1)) : sample_in;
    assign d_next    = (mag_reg > min_reg) ? (mag_reg - min_reg) : '0;
    assign span_next = max_reg - min_reg;

    assign s1     = DW'(span_reg);
    assign s2     = s1 << 1;
    assign s89    = s1 * DW'(89);
    assign s9     = s1 * DW'(9);
    assign d100   = DW'(d_reg) * DW'(100);
    assign d10    = DW'(d_reg) * DW'(10);
    assign num_up = d10 - s9;

    assign u_val   = div_quo[16:0];
    assign g_val   = 19'd262144 - 19'd3 * 19'(u_val);
    assign f_raw   = prod_reg[44:16];
    assign f_clamp = (f_raw > 29'd65536) ? 17'd65536 : f_raw[16:0];
    assign l_val   = dir_reg ? (a_reg + prod_reg[32:16]) : (a_reg - prod_reg[32:16]);
    assign blend_f = (cmd.op == MOP_MUL_BLEND_SIG) ? l_val : f_clamp;
    assign up_dir  = peak_reg >= floor_reg;
    assign diff_pf = up_dir ? (peak_reg - floor_reg) : (floor_reg - peak_reg);
    assign drop    = prod_reg[44:18];

    assign idx  = prod_reg[16 +: IDX_W];
    assign idx0 = IW'(idx);
    assign idx1 = IW'(idx) + IW'(1);
    assign ta   = LOGI_ROM[idx0];
    assign tb   = LOGI_ROM[idx1];

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = s1;
        mul_a     = '0;
        mul_b     = '0;
        res_next  = res_reg;
        unique case (cmd.op)
            MOP_DIV_LIN: begin
                div_start = 1'b1;
                div_num   = NW'(d_reg) << 13;
            end
            MOP_DIV_MID: begin
                div_start = 1'b1;
                div_num   = {d100 - s1, 16'd0};
                div_den   = s89;
            end
            MOP_DIV_UP: begin
                div_start = 1'b1;
                div_num   = {num_up, 16'd0};
            end
            MOP_MUL_UU, MOP_MUL_W2: begin
                mul_a = 26'(u_val);
                mul_b = 19'(u_val);
            end
            MOP_MUL_U3: begin
                mul_a = 26'(prod_reg[33:16]);
                mul_b = 19'(u_val);
            end
            MOP_MUL_F: begin
                mul_a = 26'(g_val);
                mul_b = prod_reg[34:16];
            end
            MOP_MUL_POS: begin
                mul_a = 26'(u_val);
                mul_b = 19'(LOGISTIC_TABLE_DEPTH);
            end
            MOP_MUL_INTERP: begin
                mul_a = (tb >= ta) ? 26'(tb - ta) : 26'(ta - tb);
                mul_b = 19'(prod_reg[15:0]);
            end
            MOP_MUL_BLEND_POLY, MOP_MUL_BLEND_SIG: begin
                mul_a = 26'(diff_pf);
                mul_b = 19'(blend_f);
            end
            MOP_MUL_DROP: begin
                mul_a = 26'(peak_reg) * 26'd3;
                mul_b = 19'(prod_reg[33:16]);
            end
            MOP_RES_LIN:   res_next = (|div_quo[NW-1:DENS_W]) ? '1 : div_quo[DENS_W-1:0];
            MOP_RES_BLEND: res_next = up_dir ? (floor_reg + prod_reg[39:16])
                                             : (floor_reg - prod_reg[39:16]);
            MOP_RES_DROP:  res_next = (drop >= 27'(peak_reg)) ? '0 : (peak_reg - drop[23:0]);
            MOP_RES_FLOOR, MOP_RES_DEGEN: res_next = floor_reg;
            MOP_RES_PEAK:  res_next = peak_reg;
            MOP_RES_ZERO:  res_next = '0;
            default: ;
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    mdm_divider #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_RESET;
            peak_reg      <= PEAK_RESET;
            floor_reg     <= FLOOR_RESET;
            min_reg       <= '1;
            max_reg       <= '0;
            any_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_addr)
                    REG_MODE:  mode_reg  <= cfg_data[1:0];
                    REG_PEAK:  peak_reg  <= cfg_data;
                    REG_FLOOR: floor_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == MOP_CLEAR) begin
                min_reg      <= '1;
                max_reg      <= '0;
                any_seen_reg <= 1'b0;
            end else if (cmd.op == MOP_ACCUM) begin
                if (mag_reg < min_reg) min_reg <= mag_reg;
                if (mag_reg > max_reg) max_reg <= mag_reg;
                any_seen_reg <= 1'b1;
            end
            if (cmd.op == MOP_OUT) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        res_reg  <= res_next;
        if (cmd.op == MOP_LATCH) begin
            cmd_reg <= cmd_in;
            mag_reg <= mag_in;
        end
        if (cmd.op == MOP_PREP) begin
            d_reg    <= d_next;
            span_reg <= span_next;
        end
        if (cmd.op == MOP_MUL_INTERP) begin
            a_reg   <= ta;
            dir_reg <= tb >= ta;
        end
        if (cmd.op == MOP_RES_DEGEN) res_degen_reg <= 1'b1;
        else if (cmd.op == MOP_PREP) res_degen_reg <= 1'b0;
        if (cmd.op == MOP_OUT) begin
            out_data_reg  <= res_reg;
            out_degen_reg <= res_degen_reg;
        end
    end

    always_comb begin
        stat.cmd      = cmd_reg;
        stat.mode     = mode_reg;
        stat.degen    = !any_seen_reg || (max_reg <= min_reg);
        stat.low      = d100 <= s1;
        stat.mid      = d10 < s9;
        stat.up_zero  = num_up >= s2;
        stat.div_busy = div_busy;
        stat.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid     = out_valid_reg;
    assign m_density    = out_data_reg;
    assign m_degenerate = out_degen_reg;

`ifndef SYNTH
    a_minmax_order: assert property (@(posedge aclk) disable iff (!aresetn)
        any_seen_reg |-> (min_reg <= max_reg))
        else $error("min above max with samples seen");
    a_empty_stats: assert property (@(posedge aclk) disable iff (!aresetn)
        !any_seen_reg |-> (min_reg == '1 && max_reg == '0))
        else $error("statistics not at reset values while empty");
    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == MOP_OUT) |=> out_valid_reg)
        else $error("result lost on output load");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == MOP_DIV_LIN || cmd.op == MOP_DIV_MID || cmd.op == MOP_DIV_UP)
        |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule

// ----- rtl/mdm_controller.sv -----
// Controller state machine: sequences micro-ops for one request at a time.
// Depends on mdm_pkg.
module mdm_controller
    import mdm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = MOP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    cmd.op     = MOP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                unique case (stat.cmd)
                    CMD_CLEAR: cmd.op = MOP_CLEAR;
                    CMD_ACCUM: cmd.op = MOP_ACCUM;
                    CMD_MAP: begin
                        if (stat.degen) begin
                            cmd.op     = MOP_RES_DEGEN;
                            state_next = ST_OUT;
                        end else begin
                            cmd.op     = MOP_PREP;
                            state_next = ST_BRANCH;
                        end
                    end
                    default: ;
                endcase
            end
            ST_BRANCH: begin
                if (stat.mode == MODE_LIN) begin
                    cmd.op     = MOP_DIV_LIN;
                    state_next = ST_DIV_LIN;
                end else if (stat.low) begin
                    cmd.op     = MOP_RES_FLOOR;
                    state_next = ST_OUT;
                end else if (stat.mid) begin
                    cmd.op     = MOP_DIV_MID;
                    state_next = ST_DIV_MID;
                end else if (stat.mode == MODE_SIG) begin
                    cmd.op     = MOP_RES_PEAK;
                    state_next = ST_OUT;
                end else if (stat.up_zero) begin
                    cmd.op     = MOP_RES_ZERO;
                    state_next = ST_OUT;
                end else begin
                    cmd.op     = MOP_DIV_UP;
                    state_next = ST_DIV_UP;
                end
            end
            ST_DIV_LIN: if (!stat.div_busy) state_next = ST_LIN_RES;
            ST_LIN_RES: begin
                cmd.op     = MOP_RES_LIN;
                state_next = ST_OUT;
            end
            ST_DIV_MID: begin
                if (!stat.div_busy) begin
                    state_next = (stat.mode == MODE_SIG) ? ST_SIG_POS : ST_POLY_U2;
                end
            end
            ST_POLY_U2: begin
                cmd.op     = MOP_MUL_UU;
                state_next = ST_POLY_U3;
            end
            ST_POLY_U3: begin
                cmd.op     = MOP_MUL_U3;
                state_next = ST_POLY_F;
            end
            ST_POLY_F: begin
                cmd.op     = MOP_MUL_F;
                state_next = ST_POLY_BLEND;
            end
            ST_POLY_BLEND: begin
                cmd.op     = MOP_MUL_BLEND_POLY;
                state_next = ST_BLEND_RES;
            end
            ST_SIG_POS: begin
                cmd.op     = MOP_MUL_POS;
                state_next = ST_SIG_INTERP;
            end
            ST_SIG_INTERP: begin
                cmd.op     = MOP_MUL_INTERP;
                state_next = ST_SIG_BLEND;
            end
            ST_SIG_BLEND: begin
                cmd.op     = MOP_MUL_BLEND_SIG;
                state_next = ST_BLEND_RES;
            end
            ST_BLEND_RES: begin
                cmd.op     = MOP_RES_BLEND;
                state_next = ST_OUT;
            end
            ST_DIV_UP: if (!stat.div_busy) state_next = ST_UP_W2;
            ST_UP_W2: begin
                cmd.op     = MOP_MUL_W2;
                state_next = ST_UP_DROP;
            end
            ST_UP_DROP: begin
                cmd.op     = MOP_MUL_DROP;
                state_next = ST_UP_RES;
            end
            ST_UP_RES: begin
                cmd.op     = MOP_RES_DROP;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.op     = MOP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
